[sv/imu_complementary_attitude_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the attitude core
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef IMU_COMPLEMENTARY_ATTITUDE_CORE_ASSERT_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define IAC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define IAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/iac_pkg.sv]
// ---------------------------------------------------------------------------
// iac_pkg
// Shared constants, widths and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package iac_pkg;

    localparam int unsigned MUL_W  = 34;          // multiplier operand width
    localparam int unsigned PROD_W = 2 * MUL_W;   // product width
    localparam int unsigned ANG_W  = 25;          // output angle width
    localparam int unsigned CX_W   = 36;          // CORDIC x/y width
    localparam int unsigned CZ_W   = 33;          // CORDIC z width
    localparam int unsigned CORDIC_STEPS = 24;

    localparam logic signed [MUL_W-1:0] DEG90  = 34'sd5898240;
    localparam logic signed [MUL_W-1:0] DEG180 = 34'sd11796480;
    localparam logic signed [MUL_W-1:0] DEG360 = 34'sd23592960;
    localparam logic signed [CX_W-1:0]  INV_GAIN = 36'sd652032874;

    // register indexes and reset values
    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_WEIGHT = 1'b1;
    localparam logic [19:0] PERIOD_RESET = 20'd16777;
    localparam logic [15:0] WEIGHT_RESET = 16'd65405;

    // atan(2^-i) in 2^-24 degree
    function automatic logic [29:0] atan_lut(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd754974720;
            5'd1:  v = 30'd445687602;
            5'd2:  v = 30'd235489088;
            5'd3:  v = 30'd119537938;
            5'd4:  v = 30'd60000934;
            5'd5:  v = 30'd30029717;
            5'd6:  v = 30'd15018523;
            5'd7:  v = 30'd7509720;
            5'd8:  v = 30'd3754917;
            5'd9:  v = 30'd1877466;
            5'd10: v = 30'd938734;
            5'd11: v = 30'd469367;
            5'd12: v = 30'd234684;
            5'd13: v = 30'd117342;
            5'd14: v = 30'd58671;
            5'd15: v = 30'd29335;
            5'd16: v = 30'd14668;
            5'd17: v = 30'd7334;
            5'd18: v = 30'd3667;
            5'd19: v = 30'd1833;
            5'd20: v = 30'd917;
            5'd21: v = 30'd458;
            5'd22: v = 30'd229;
            5'd23: v = 30'd115;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

[sv/imu_complementary_attitude_core.sv]
// ---------------------------------------------------------------------------
// imu_complementary_attitude_core
// Complementary-filter attitude estimator: accelerometer tilt by CORDIC,
// gyro integration with yaw coupling, wrap and blend with weight alpha.
// ---------------------------------------------------------------------------
// Usage:
//   Input items on s_axis_*: six signed 16-bit fields (three accel axes,
//   three gyro rates). Each accepted item yields exactly one result item on
//   m_axis_*: roll, pitch (25 bit) and yaw (32 bit) in 2^-16 degree.
//   Configuration via i_cfg_we / i_cfg_idx / i_cfg_wdata while idle:
//   index 0 sample period, index 1 blend weight.
//   One item at a time: s_axis_tready is high only in the idle state.
//   Each item runs through the bit-serial multiplier (three products on
//   every item and seven more after the first), the bit-serial square
//   root and the CORDIC; a tilt whose other two axes are both zero skips
//   its root and CORDIC. Later samples also pass the wrap, which removes
//   extra turns until both angles lie in [-180,180]. The next item can be
//   taken in the cycle after the result loads.
//   The result sits in an output register; the next item is accepted while
//   it waits. If the receiver still stalls when the following result is
//   ready, the core holds in its final state until the register frees.
//   Synchronous reset restores the register defaults, zero estimates and
//   the first-sample flag.
// ---------------------------------------------------------------------------
module imu_complementary_attitude_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // accel_x, accel_y, accel_z, rate_roll, rate_pitch, rate_yaw (16 b each)
    input  logic [95:0] s_axis_tdata,
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // roll_angle [24:0], pitch_angle [49:25], yaw_angle [81:50], zero fill
    output logic [87:0] m_axis_tdata,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [19:0] i_cfg_wdata
);
    import iac_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ_X, S_SQ_Y, S_SQ_Z, S_PSQRT, S_PCORD, S_RSQRT, S_RCORD,
        S_INIT, S_RATE_X, S_RATE_Y, S_RATE_Z, S_SIN, S_COUP_R, S_COUP_P,
        S_WRAP, S_BLEND_R, S_BLEND_P, S_DONE
    } t_state;

    t_state r_state;
    logic   r_wait;
    logic   r_first;
    logic   r_out_valid;

    logic [19:0] r_period;
    logic [15:0] r_weight;

    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy, r_gz;
    logic [31:0] r_sx, r_sy, r_sz;
    logic [31:0] r_root;
    logic signed [ANG_W-1:0] r_tilt_r, r_tilt_p;
    logic signed [ANG_W-1:0] r_roll_est, r_pitch_est;
    logic signed [31:0]      r_yaw;
    logic signed [ANG_W-1:0] r_dz;
    logic signed [MUL_W-1:0] r_roll, r_pitch, r_s;
    logic signed [ANG_W-1:0] r_o_roll, r_o_pitch;
    logic signed [31:0]      r_o_yaw;

    // unit hookup
    logic                     mul_start, mul_done;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_prod;
    logic                     sqrt_start, sqrt_done;
    logic [31:0]              sqrt_rad, sqrt_root;
    logic                     cord_start, cord_done, cord_rot;
    logic signed [CX_W-1:0]   cord_x, cord_y, cord_yo;
    logic signed [CZ_W-1:0]   cord_z, cord_zo;

    logic                     skip_p, skip_r, out_load;
    logic signed [PROD_W-1:0] rnd12, rnd30, rnd16;
    logic signed [ANG_W-1:0]  d_inc;
    logic signed [MUL_W-1:0]  cpl, blend_add, dz_ext, a_red;
    logic signed [CZ_W-1:0]   z_rnd;
    logic signed [ANG_W-1:0]  tilt_new;
    logic                     roll_in, pitch_in;

    iac_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_prod(mul_prod)
    );

    iac_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sqrt_start),
        .i_rad(sqrt_rad), .o_done(sqrt_done), .o_root(sqrt_root)
    );

    iac_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cord_start), .i_rot(cord_rot),
        .i_x(cord_x), .i_y(cord_y), .i_z(cord_z),
        .o_done(cord_done), .o_y(cord_yo), .o_z(cord_zo)
    );

    // tilt exists only if the other two axes are not both zero
    assign skip_p = (r_ay == 16'sd0) && (r_az == 16'sd0);
    assign skip_r = (r_ax == 16'sd0) && (r_az == 16'sd0);

    // unit launches
    always_comb begin
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        cord_start = 1'b0;
        if (!r_wait) begin
            unique case (r_state)
                S_SQ_X, S_SQ_Y, S_SQ_Z, S_RATE_X, S_RATE_Y, S_RATE_Z,
                S_COUP_R, S_COUP_P, S_BLEND_R, S_BLEND_P: mul_start = 1'b1;
                S_PSQRT: sqrt_start = !skip_p;
                S_RSQRT: sqrt_start = !skip_r;
                S_PCORD, S_RCORD, S_SIN: cord_start = 1'b1;
                default: ;
            endcase
        end
    end

    // multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQ_X: begin mul_a = MUL_W'(r_ax); mul_b = MUL_W'(r_ax); end
            S_SQ_Y: begin mul_a = MUL_W'(r_ay); mul_b = MUL_W'(r_ay); end
            S_SQ_Z: begin mul_a = MUL_W'(r_az); mul_b = MUL_W'(r_az); end
            S_RATE_X: begin mul_a = MUL_W'(r_gx); mul_b = $signed(MUL_W'(r_period)); end
            S_RATE_Y: begin mul_a = MUL_W'(r_gy); mul_b = $signed(MUL_W'(r_period)); end
            S_RATE_Z: begin mul_a = MUL_W'(r_gz); mul_b = $signed(MUL_W'(r_period)); end
            S_COUP_R: begin mul_a = r_s; mul_b = r_pitch; end
            S_COUP_P: begin mul_a = r_s; mul_b = r_roll; end
            S_BLEND_R: begin
                mul_a = r_roll - MUL_W'(r_tilt_r);
                mul_b = $signed(MUL_W'(r_weight));
            end
            S_BLEND_P: begin
                mul_a = r_pitch - MUL_W'(r_tilt_p);
                mul_b = $signed(MUL_W'(r_weight));
            end
            default: ;
        endcase
    end

    // sqrt and CORDIC operands; sine angle folded into [-90,90]
    always_comb begin
        dz_ext = MUL_W'(r_dz);
        if (dz_ext > DEG90) begin
            a_red = DEG180 - dz_ext;
        end else if (dz_ext < -DEG90) begin
            a_red = -DEG180 - dz_ext;
        end else begin
            a_red = dz_ext;
        end
        sqrt_rad = (r_state == S_RSQRT) ? (r_sx + r_sz) : (r_sy + r_sz);
        cord_rot = (r_state == S_SIN);
        cord_x   = cord_rot ? INV_GAIN : $signed({4'b0000, r_root});
        cord_y   = '0;
        cord_z   = '0;
        if (r_state == S_PCORD) begin
            cord_y = $signed({{4{r_ax[15]}}, r_ax, 16'h0000});
        end else if (r_state == S_RCORD) begin
            cord_y = $signed({{4{r_ay[15]}}, r_ay, 16'h0000});
        end else begin
            cord_z = $signed({a_red[24:0], 8'h00});
        end
    end

    // rounding of products and CORDIC angle
    always_comb begin
        rnd12     = mul_prod + PROD_W'(2048);
        rnd30     = mul_prod + PROD_W'(64'sd536870912);
        rnd16     = mul_prod + PROD_W'(32768);
        d_inc     = rnd12[36:12];
        cpl       = rnd30[63:30];
        blend_add = rnd16[49:16];
        z_rnd     = cord_zo + CZ_W'(128);
        tilt_new  = z_rnd[32:8];
        roll_in   = (r_roll <= DEG180) && (r_roll >= -DEG180);
        pitch_in  = (r_pitch <= DEG180) && (r_pitch >= -DEG180);
        out_load  = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_weight <= WEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PERIOD: r_period <= i_cfg_wdata;
                CFG_WEIGHT: r_weight <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
            r_tilt_r    <= '0;
            r_tilt_p    <= '0;
            r_roll_est  <= '0;
            r_pitch_est <= '0;
            r_yaw       <= '0;
        end else begin
            if (mul_start || sqrt_start || cord_start) begin
                r_wait <= 1'b1;
            end
            if (m_axis_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_ax    <= s_axis_tdata[15:0];
                        r_ay    <= s_axis_tdata[31:16];
                        r_az    <= s_axis_tdata[47:32];
                        r_gx    <= s_axis_tdata[63:48];
                        r_gy    <= s_axis_tdata[79:64];
                        r_gz    <= s_axis_tdata[95:80];
                        r_state <= S_SQ_X;
                    end
                end
                S_SQ_X: if (mul_done) begin
                    r_sx <= mul_prod[31:0]; r_wait <= 1'b0; r_state <= S_SQ_Y;
                end
                S_SQ_Y: if (mul_done) begin
                    r_sy <= mul_prod[31:0]; r_wait <= 1'b0; r_state <= S_SQ_Z;
                end
                S_SQ_Z: if (mul_done) begin
                    r_sz <= mul_prod[31:0]; r_wait <= 1'b0; r_state <= S_PSQRT;
                end
                S_PSQRT: begin
                    if (skip_p) begin
                        r_state <= S_RSQRT;
                    end else if (sqrt_done) begin
                        r_root <= sqrt_root; r_wait <= 1'b0; r_state <= S_PCORD;
                    end
                end
                S_PCORD: if (cord_done) begin
                    r_tilt_p <= -tilt_new; r_wait <= 1'b0; r_state <= S_RSQRT;
                end
                S_RSQRT: begin
                    if (skip_r) begin
                        r_state <= S_INIT;
                    end else if (sqrt_done) begin
                        r_root <= sqrt_root; r_wait <= 1'b0; r_state <= S_RCORD;
                    end
                end
                S_RCORD: if (cord_done) begin
                    r_tilt_r <= tilt_new; r_wait <= 1'b0; r_state <= S_INIT;
                end
                S_INIT: begin
                    if (r_first) begin
                        r_roll_est  <= r_tilt_r;
                        r_pitch_est <= r_tilt_p;
                        r_yaw       <= '0;
                        r_first     <= 1'b0;
                        r_state     <= S_DONE;
                    end else begin
                        r_state <= S_RATE_X;
                    end
                end
                S_RATE_X: if (mul_done) begin
                    r_roll  <= MUL_W'(r_roll_est) + MUL_W'(d_inc);
                    r_wait  <= 1'b0;
                    r_state <= S_RATE_Y;
                end
                S_RATE_Y: if (mul_done) begin
                    r_pitch <= MUL_W'(r_pitch_est) + MUL_W'(d_inc);
                    r_wait  <= 1'b0;
                    r_state <= S_RATE_Z;
                end
                S_RATE_Z: if (mul_done) begin
                    r_dz    <= d_inc;
                    r_yaw   <= r_yaw + 32'(d_inc);
                    r_wait  <= 1'b0;
                    r_state <= S_SIN;
                end
                S_SIN: if (cord_done) begin
                    r_s <= cord_yo[MUL_W-1:0]; r_wait <= 1'b0; r_state <= S_COUP_R;
                end
                S_COUP_R: if (mul_done) begin
                    r_roll <= r_roll + cpl; r_wait <= 1'b0; r_state <= S_COUP_P;
                end
                S_COUP_P: if (mul_done) begin
                    r_pitch <= r_pitch - cpl; r_wait <= 1'b0; r_state <= S_WRAP;
                end
                // one turn per cycle until both lie in [-180,180]
                S_WRAP: begin
                    if (r_roll > DEG180) begin
                        r_roll <= r_roll - DEG360;
                    end else if (r_roll < -DEG180) begin
                        r_roll <= r_roll + DEG360;
                    end
                    if (r_pitch > DEG180) begin
                        r_pitch <= r_pitch - DEG360;
                    end else if (r_pitch < -DEG180) begin
                        r_pitch <= r_pitch + DEG360;
                    end
                    if (roll_in && pitch_in) begin
                        r_state <= S_BLEND_R;
                    end
                end
                // tilt + alpha*(angle - tilt), rounded
                S_BLEND_R: if (mul_done) begin
                    r_roll_est <= ANG_W'(MUL_W'(r_tilt_r) + blend_add);
                    r_wait     <= 1'b0;
                    r_state    <= S_BLEND_P;
                end
                S_BLEND_P: if (mul_done) begin
                    r_pitch_est <= ANG_W'(MUL_W'(r_tilt_p) + blend_add);
                    r_wait      <= 1'b0;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_o_roll    <= r_roll_est;
                        r_o_pitch   <= r_pitch_est;
                        r_o_yaw     <= r_yaw;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b000000, r_o_yaw, r_o_pitch, r_o_roll};

    `include "imu_complementary_attitude_core_assert.svh"

    `IAC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "core took a second item while busy")
    `IAC_ASSERT_SAME(a_done_when_waiting, mul_done || sqrt_done || cord_done, r_wait, "unit finished with no launch pending")
    `IAC_ASSERT_SAME(a_wrapped_before_blend, r_state == S_BLEND_R, roll_in && pitch_in, "angle outside one half-turn at blend")
    `IAC_ASSERT_NEXT(a_load_sets_valid, out_load, m_axis_tvalid, "result load lost")

endmodule

[sv/iac_mul.sv]
// ---------------------------------------------------------------------------
// iac_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add with
// a narrow adder, sign bit subtracted on the last step.
// ---------------------------------------------------------------------------
module iac_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [iac_pkg::MUL_W-1:0]     i_a,
    input  logic signed [iac_pkg::MUL_W-1:0]     i_b,
    output logic                                 o_done,
    output logic signed [iac_pkg::PROD_W-1:0]    o_prod
);
    import iac_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [5:0]              r_cnt;
    logic signed [MUL_W-1:0] r_a;
    logic signed [MUL_W:0]   r_hi;
    logic [MUL_W-1:0]        r_lo;
    logic signed [MUL_W:0]   a_ext;
    logic signed [MUL_W:0]   addend;
    logic signed [MUL_W:0]   sum;
    logic                    last;

    // partial product for the current bit
    always_comb begin
        last   = (r_cnt == 6'(MUL_W - 1));
        a_ext  = {r_a[MUL_W-1], r_a};
        addend = '0;
        if (r_lo[0]) begin
            addend = last ? -a_ext : a_ext;
        end
        sum = r_hi + addend;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= {sum[MUL_W], sum[MUL_W:1]};
            r_lo <= {sum[0], r_lo[MUL_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi[MUL_W-1:0], r_lo};

endmodule

[sv/iac_sqrt.sv]
// ---------------------------------------------------------------------------
// iac_sqrt
// Restoring square root of (radicand * 2^32), one root bit per cycle.
// ---------------------------------------------------------------------------
module iac_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);
    import iac_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_src;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;

    // trial subtraction
    always_comb begin
        rem_sh = {r_rem[32:0], r_src[31:30]};
        trial  = {1'b0, r_root, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // low 32 bits of the scaled radicand are zero: fed in after the source
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_src  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_src  <= {r_src[29:0], 2'b00};
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[sv/iac_cordic.sv]
// ---------------------------------------------------------------------------
// iac_cordic
// Iterative CORDIC, one micro-rotation per cycle; vectoring or rotation mode.
// ---------------------------------------------------------------------------
module iac_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_rot,
    input  logic signed [iac_pkg::CX_W-1:0]   i_x,
    input  logic signed [iac_pkg::CX_W-1:0]   i_y,
    input  logic signed [iac_pkg::CZ_W-1:0]   i_z,
    output logic                              o_done,
    output logic signed [iac_pkg::CX_W-1:0]   o_y,
    output logic signed [iac_pkg::CZ_W-1:0]   o_z
);
    import iac_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic                   r_rot;
    logic [4:0]             r_i;
    logic signed [CX_W-1:0] r_x;
    logic signed [CX_W-1:0] r_y;
    logic signed [CZ_W-1:0] r_z;
    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    logic signed [CZ_W-1:0] t;
    logic                   sigma;

    // shifted terms and direction
    always_comb begin
        xs    = r_x >>> r_i;
        ys    = r_y >>> r_i;
        t     = $signed({3'b000, atan_lut(r_i)});
        sigma = r_rot ? r_z[CZ_W-1] : !r_y[CX_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 5'd1;
                if (r_i == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rot <= i_rot;
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
        end else if (r_busy) begin
            if (sigma) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + t;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - t;
            end
        end
    end

    assign o_done = r_done;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule
